@@ rtl/adc_scan_leaky_average_top_macros.svh @@
// ---------------------------------------------------------------------------
// adc scan leaky average: assertion macros
// shared property wrappers, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef ADC_SCAN_LEAKY_AVERAGE_TOP_MACROS_SVH
`define ADC_SCAN_LEAKY_AVERAGE_TOP_MACROS_SVH

// same-cycle implication
`define ADC_SLA_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ADC_SLA_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/adc_sla_pkg.sv @@
// ---------------------------------------------------------------------------
// adc scan leaky average: package
// widths, codes, state types and inter-module structs
// ---------------------------------------------------------------------------
package adc_sla_pkg;

  localparam int NUM_SLOTS_DEF   = 3;
  localparam int SAMPLE_BITS_DEF = 12;

  localparam int DEPTH     = 8;
  localparam int SLOT_W    = 3;
  localparam int SAMPLE_W  = 12;
  localparam int ACC_W     = 24;
  localparam int AVG_W     = 12;
  localparam int MV_W      = 16;
  localparam int FS_W      = 4;
  localparam int REFMV_W   = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 12;

  localparam logic [FS_W-1:0]      FS_MAX        = 4'd8;
  localparam logic [FS_W-1:0]      FS_RESET      = 4'd3;
  localparam logic [REFMV_W-1:0]   REFMV_RESET   = 12'd1230;
  localparam logic [SLOT_W-1:0]    REFSLOT_RESET = 3'd2;

  localparam int MUL_STEPS = 12;
  localparam int DIV_STEPS = 16;
  localparam int MD_CNT_W  = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_START = 2'd2,
    CMD_PAUSE = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_SHIFT = 2'd0,
    REG_REF_MV       = 2'd1,
    REG_REF_SLOT     = 2'd2,
    REG_AUTO_RESTART = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    TS_IDLE,
    TS_DECODE,
    TS_FOLD,
    TS_RD_AVG,
    TS_RD_REF,
    TS_MDIV,
    TS_RESULT
  } top_state_t;

  typedef enum logic [2:0] {
    MD_IDLE,
    MD_MUL,
    MD_CHECK,
    MD_DIV,
    MD_DONE
  } md_state_t;

  typedef struct packed {
    logic                start;
    logic [SLOT_W-1:0]   slot;
    logic [SAMPLE_W-1:0] sample;
    logic [FS_W-1:0]     shift;
  } fold_req_t;

  typedef struct packed {
    logic             done;
    logic [AVG_W-1:0] avg;
  } fold_rsp_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] addr;
    logic [AVG_W-1:0]  data;
  } avg_wr_t;

  typedef struct packed {
    logic               start;
    logic [AVG_W-1:0]   avg;
    logic [AVG_W-1:0]   ref_avg;
    logic [REFMV_W-1:0] ref_mv;
  } mdiv_req_t;

  typedef struct packed {
    logic            done;
    logic [MV_W-1:0] mv;
  } mdiv_rsp_t;

endpackage

@@ rtl/adc_scan_leaky_average_top.sv @@
// ---------------------------------------------------------------------------
// adc scan leaky average: top level
// Round-robin scanner over NUM_SLOTS converter slots with a leaky-integrator
// average per slot and a millivolt read-back. One item is handled at a time;
// a finished result sits in the output register, so the next item can be
// taken while it waits. Start, pause, and ticks that open a slot or do
// nothing go straight from decode to the result state. A tick that folds
// a sample shifts by filter_shift (clamped to 8) one bit per cycle to form
// the average. A read fetches the slot and reference averages, then runs
// the bit-serial 12-step multiply and the 16-step restoring divide in the
// millivolt unit, skipping the divide when the quotient saturates. Config
// writes are always ready and must only be issued while the block is idle.
// ---------------------------------------------------------------------------
module adc_scan_leaky_average_top
  import adc_sla_pkg::*;
#(
  parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,

  // input item channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           command,
  input  logic                 conversion_done,
  input  logic [SAMPLE_W-1:0]  sample,
  input  logic [SLOT_W-1:0]    read_slot,

  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 open_strobe,
  output logic [SLOT_W-1:0]    channel_slot,
  output logic                 sample_taken,
  output logic [AVG_W-1:0]     slot_average,
  output logic [MV_W-1:0]      slot_millivolts,
  output logic                 scan_done,
  output logic                 scan_enabled,

  // config write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  // slot count as a width-matched constant for compares
  localparam logic [SLOT_W:0] NUM_SLOTS_L = (SLOT_W+1)'(NUM_SLOTS);
  // samples narrower than the port are masked down
  localparam int              SMP_KEEP = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam logic [SAMPLE_W-1:0] SMP_MASK = SAMPLE_W'((1 << SMP_KEEP) - 1);

  top_state_t state, state_next;

  // config registers
  logic [FS_W-1:0]     filter_shift;
  logic [REFMV_W-1:0]  ref_mv;
  logic [SLOT_W-1:0]   ref_slot;
  logic                auto_restart;

  // scan state
  logic [SLOT_W-1:0]   cur_slot;
  logic                pending;
  logic                enabled;

  // latched item
  cmd_t                cmd_q;
  logic                done_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic [SLOT_W-1:0]   rslot_q;

  // result being built
  logic                res_strobe;
  logic [SLOT_W-1:0]   res_chan;
  logic                res_taken;
  logic [AVG_W-1:0]    res_avg;
  logic [MV_W-1:0]     res_mv;
  logic                res_sdone;

  // sub-unit links
  fold_req_t           fold_req;
  fold_rsp_t           fold_rsp;
  avg_wr_t             avg_wr;
  logic [SLOT_W-1:0]   mem_rd_addr;
  logic [AVG_W-1:0]    mem_rd_data;
  mdiv_req_t           mdiv_req;
  mdiv_rsp_t           mdiv_rsp;

  logic                in_xfer;
  logic                out_load;
  logic                do_fold;
  logic [SLOT_W:0]     slot_inc;

  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && !in_stall;

  // a tick with a conversion outstanding and a finished sample folds it in
  assign do_fold  = (cmd_q == CMD_TICK) && enabled && pending && done_q;
  assign slot_inc = {1'b0, cur_slot} + 1'b1;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      TS_IDLE:   if (in_valid) state_next = TS_DECODE;
      TS_DECODE: begin
        if (do_fold) begin
          state_next = TS_FOLD;
        end else if (cmd_q == CMD_READ) begin
          state_next = TS_RD_AVG;
        end else begin
          state_next = TS_RESULT;
        end
      end
      TS_FOLD:   if (fold_rsp.done) state_next = TS_RESULT;
      TS_RD_AVG: state_next = TS_RD_REF;
      TS_RD_REF: state_next = TS_MDIV;
      TS_MDIV:   if (mdiv_rsp.done) state_next = TS_RESULT;
      TS_RESULT: if (!out_valid || !out_stall) state_next = TS_IDLE;
      default:   state_next = TS_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall        = (state != TS_IDLE);
    out_load        = (state == TS_RESULT) && (!out_valid || !out_stall);

    fold_req.start  = (state == TS_DECODE) && do_fold;
    fold_req.slot   = cur_slot;
    fold_req.sample = sample_q & SMP_MASK;
    fold_req.shift  = filter_shift;

    avg_wr.we       = (state == TS_FOLD) && fold_rsp.done;
    avg_wr.addr     = cur_slot;
    avg_wr.data     = fold_rsp.avg;

    // read slot first, then reference slot on the following cycle
    mem_rd_addr     = (state == TS_DECODE) ? rslot_q : ref_slot;

    mdiv_req.start   = (state == TS_RD_REF);
    mdiv_req.avg     = res_avg;
    mdiv_req.ref_avg = mem_rd_data;
    mdiv_req.ref_mv  = ref_mv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= TS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_shift <= FS_RESET;
      ref_mv       <= REFMV_RESET;
      ref_slot     <= REFSLOT_RESET;
      auto_restart <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FILTER_SHIFT: filter_shift <= cfg_data[FS_W-1:0];
        REG_REF_MV:       ref_mv       <= cfg_data[REFMV_W-1:0];
        REG_REF_SLOT:     ref_slot     <= cfg_data[SLOT_W-1:0];
        REG_AUTO_RESTART: auto_restart <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // scan control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_slot <= '0;
      pending  <= 1'b0;
      enabled  <= 1'b1;
    end else if (state == TS_DECODE) begin
      unique case (cmd_q)
        CMD_TICK: begin
          if (enabled && !pending) begin
            pending <= 1'b1;
            // out-of-range slot wraps to slot 0 on open
            if ({1'b0, cur_slot} >= NUM_SLOTS_L) begin
              cur_slot <= '0;
            end
          end
        end
        CMD_START: begin
          cur_slot <= '0;
          pending  <= 1'b0;
          enabled  <= 1'b1;
        end
        CMD_PAUSE: enabled <= 1'b0;
        CMD_READ: begin
        end
        default: begin
        end
      endcase
    end else if ((state == TS_FOLD) && fold_rsp.done) begin
      pending <= 1'b0;
      if (slot_inc >= NUM_SLOTS_L) begin
        // end of scan: wrap, and stop unless auto-restart
        cur_slot <= '0;
        enabled  <= auto_restart;
      end else begin
        cur_slot <= slot_inc[SLOT_W-1:0];
      end
    end
  end

  // item latch and result build-up
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_q    <= cmd_t'(command);
      done_q   <= conversion_done;
      sample_q <= sample;
      rslot_q  <= read_slot;
    end

    unique case (state)
      TS_DECODE: begin
        res_strobe <= 1'b0;
        res_chan   <= '0;
        res_taken  <= 1'b0;
        res_avg    <= '0;
        res_mv     <= '0;
        res_sdone  <= 1'b0;
        if ((cmd_q == CMD_TICK) && enabled && !pending) begin
          res_strobe <= 1'b1;
          res_chan   <= ({1'b0, cur_slot} >= NUM_SLOTS_L) ? '0 : cur_slot;
        end else if (cmd_q == CMD_READ) begin
          res_chan <= rslot_q;
        end
      end
      TS_FOLD: begin
        if (fold_rsp.done) begin
          res_chan  <= cur_slot;
          res_taken <= 1'b1;
          res_avg   <= fold_rsp.avg;
          res_sdone <= (slot_inc >= NUM_SLOTS_L);
        end
      end
      TS_RD_AVG: res_avg <= mem_rd_data;
      TS_MDIV: begin
        if (mdiv_rsp.done) begin
          res_mv <= mdiv_rsp.mv;
        end
      end
      TS_IDLE, TS_RD_REF, TS_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      open_strobe     <= res_strobe;
      channel_slot    <= res_chan;
      sample_taken    <= res_taken;
      slot_average    <= res_avg;
      slot_millivolts <= res_mv;
      scan_done       <= res_sdone;
      scan_enabled    <= enabled;
    end
  end

  adc_sla_fold u_fold (
    .clk (clk),
    .rst (rst),
    .req (fold_req),
    .rsp (fold_rsp)
  );

  adc_sla_avg_mem u_avg_mem (
    .clk     (clk),
    .rst     (rst),
    .wr      (avg_wr),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  adc_sla_mdiv u_mdiv (
    .clk (clk),
    .rst (rst),
    .req (mdiv_req),
    .rsp (mdiv_rsp)
  );

endmodule

@@ rtl/adc_sla_fold.sv @@
// ---------------------------------------------------------------------------
// adc sla fold
// per-slot leaky integrator: add, bit-serial right shift, take average off
// ---------------------------------------------------------------------------
module adc_sla_fold
  import adc_sla_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  fold_req_t req,
  output fold_rsp_t rsp
);

  logic [ACC_W-1:0]  acc [DEPTH];
  logic [ACC_W-1:0]  sum_q;
  logic [ACC_W-1:0]  sh_q;
  logic [FS_W-1:0]   cnt;
  logic [SLOT_W-1:0] slot_q;
  logic              busy;

  logic [ACC_W:0]    sum_wide;
  logic [ACC_W-1:0]  sum_sat;
  logic [AVG_W-1:0]  avg_sat;
  logic              fin;

  always_comb begin
    sum_wide = {1'b0, acc[req.slot]} + (ACC_W+1)'(req.sample);
    sum_sat  = sum_wide[ACC_W] ? '1 : sum_wide[ACC_W-1:0];
    avg_sat  = (|sh_q[ACC_W-1:AVG_W]) ? '1 : sh_q[AVG_W-1:0];
    fin      = busy && (cnt == '0);
  end

  assign rsp.done = fin;
  assign rsp.avg  = avg_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        acc[i] <= '0;
      end
    end else if (req.start) begin
      busy   <= 1'b1;
      sum_q  <= sum_sat;
      sh_q   <= sum_sat;
      slot_q <= req.slot;
      cnt    <= (req.shift > FS_MAX) ? FS_MAX : req.shift;
    end else if (busy) begin
      if (cnt != '0) begin
        // one bit of shift per cycle
        sh_q <= sh_q >> 1;
        cnt  <= cnt - 1'b1;
      end else begin
        busy        <= 1'b0;
        acc[slot_q] <= sum_q - ACC_W'(avg_sat);
      end
    end
  end

endmodule

@@ rtl/adc_sla_avg_mem.sv @@
// ---------------------------------------------------------------------------
// adc sla average memory
// slot averages, one write and one registered read port, valid bits for reset
// ---------------------------------------------------------------------------
module adc_sla_avg_mem
  import adc_sla_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  avg_wr_t           wr,
  input  logic [SLOT_W-1:0] rd_addr,
  output logic [AVG_W-1:0]  rd_data
);

  logic [AVG_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    // entries never written read as zero
    rd_data <= vld[rd_addr] ? mem[rd_addr] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.we) begin
      vld[wr.addr] <= 1'b1;
    end
  end

endmodule

@@ rtl/adc_sla_mdiv.sv @@
// ---------------------------------------------------------------------------
// adc sla millivolt unit
// shift-add multiply then restoring divide, one bit per cycle, saturating
// ---------------------------------------------------------------------------
module adc_sla_mdiv
  import adc_sla_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  mdiv_req_t req,
  output mdiv_rsp_t rsp
);

  localparam int PROD_W = AVG_W + REFMV_W;
  localparam int HI_W   = PROD_W - MV_W;

  md_state_t state, state_next;

  logic [PROD_W-1:0]   mcand;
  logic [REFMV_W-1:0]  mplier;
  logic [PROD_W-1:0]   prod;
  logic [AVG_W-1:0]    ref_q;
  logic [AVG_W-1:0]    rem;
  logic [MV_W-1:0]     quo;
  logic [MD_CNT_W-1:0] cnt;

  logic                sat;
  logic [AVG_W:0]      trial;
  logic                ge;

  always_comb begin
    sat   = (ref_q == '0) || (AVG_W'(prod[PROD_W-1:MV_W]) >= ref_q);
    trial = {rem, quo[MV_W-1]};
    ge    = trial >= {1'b0, ref_q};
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      MD_IDLE:  if (req.start) state_next = MD_MUL;
      MD_MUL:   if (cnt == '0) state_next = MD_CHECK;
      MD_CHECK: state_next = sat ? MD_DONE : MD_DIV;
      MD_DIV:   if (cnt == '0) state_next = MD_DONE;
      MD_DONE:  state_next = MD_IDLE;
      default:  state_next = MD_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rsp.done = (state == MD_DONE);
    rsp.mv   = quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      MD_IDLE: begin
        if (req.start) begin
          mcand  <= PROD_W'(req.avg);
          mplier <= req.ref_mv;
          prod   <= '0;
          ref_q  <= req.ref_avg;
          cnt    <= MD_CNT_W'(MUL_STEPS - 1);
        end
      end
      MD_MUL: begin
        if (mplier[0]) begin
          prod <= prod + mcand;
        end
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        cnt    <= cnt - 1'b1;
      end
      MD_CHECK: begin
        if (sat) begin
          quo <= '1;
        end else begin
          rem <= AVG_W'(prod[PROD_W-1:MV_W]);
          quo <= prod[MV_W-1:0];
          cnt <= MD_CNT_W'(DIV_STEPS - 1);
        end
      end
      MD_DIV: begin
        // dividend bits leave the top of quo, quotient bits enter the bottom
        rem <= ge ? AVG_W'(trial - {1'b0, ref_q}) : trial[AVG_W-1:0];
        quo <= {quo[MV_W-2:0], ge};
        cnt <= cnt - 1'b1;
      end
      MD_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // high product part is narrower than the divisor
  if (HI_W > AVG_W) begin : g_width_check
    $error("product high part wider than divisor");
  end

endmodule

@@ rtl/adc_sla_checker.sv @@
// ---------------------------------------------------------------------------
// adc sla checker
// port-level checks on result consistency and output hold
// ---------------------------------------------------------------------------
`include "adc_scan_leaky_average_top_macros.svh"

module adc_sla_checker
  import adc_sla_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 open_strobe,
  input logic                 sample_taken,
  input logic [AVG_W-1:0]     slot_average,
  input logic [MV_W-1:0]      slot_millivolts,
  input logic                 scan_done
);

  // a tick either opens a slot or folds a sample, never both
  `ADC_SLA_CHECK(a_open_xor_take, out_valid, !(open_strobe && sample_taken),
                 "open and take together")

  // end of scan only on a fold
  `ADC_SLA_CHECK(a_done_on_take, out_valid && scan_done, sample_taken,
                 "scan_done without a fold")

  // millivolts zero on ticks that open or fold
  `ADC_SLA_CHECK(a_mv_read_only, out_valid && (open_strobe || sample_taken),
                 slot_millivolts == '0, "millivolts on a tick")

  // stalled result holds
  `ADC_SLA_CHECK_NEXT(a_out_hold, out_valid && out_stall,
                      out_valid && $stable(slot_average) && $stable(slot_millivolts),
                      "stalled result changed")

endmodule

bind adc_scan_leaky_average_top adc_sla_checker u_sla_checker (.*);

@@ tb/sv/adc_scan_leaky_average_top_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// adc scan leaky average: testbench
// Drives commands into the scanner and checks each result against a table
// entry or an in-bench mirror of the slot integrators, the scan pointer
// and the millivolt read-back. A short directed table opens the run, then
// random phases follow under several register settings, with random idling
// on both channels, one long result hold-off and one phase with no idling.
// ---------------------------------------------------------------------------
module adc_scan_leaky_average_top_tb;
  import adc_sla_pkg::*;

  localparam int SLOTS        = NUM_SLOTS_DEF;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 105;
  localparam int HOLD_CYCLES  = 300;
  localparam int LIMIT_CYCLES = 500000;

  typedef struct packed {
    cmd_t          cmd;
    logic          done;
    logic [11:0]   smp;
    logic [2:0]    rslot;
  } scan_item_t;

  typedef struct packed {
    logic          strobe;
    logic [2:0]    chan;
    logic          taken;
    logic [11:0]   avg;
    logic [15:0]   mv;
    logic          sdone;
    logic          en;
  } scan_result_t;

  typedef struct packed {
    scan_item_t    it;
    logic          typed;
    scan_result_t  want;
  } plan_row_t;

  // clock, reset and every block input start at known values
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           command = CMD_TICK;
  logic                 conversion_done = 1'b0;
  logic [SAMPLE_W-1:0]  sample = '0;
  logic [SLOT_W-1:0]    read_slot = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 open_strobe;
  logic [SLOT_W-1:0]    channel_slot;
  logic                 sample_taken;
  logic [AVG_W-1:0]     slot_average;
  logic [MV_W-1:0]      slot_millivolts;
  logic                 scan_done;
  logic                 scan_enabled;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FILTER_SHIFT;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  // mirror of the scanner, held at its reset state until the first transfer
  logic [23:0]  acc_mirror [DEPTH] = '{default: '0};
  logic [11:0]  avg_mirror [DEPTH] = '{default: '0};
  logic [2:0]   slot_ptr    = '0;
  logic         conv_open   = 1'b0;
  logic         scan_on     = 1'b1;
  logic [3:0]   shift_cfg   = FS_RESET;
  logic [11:0]  ref_mv_cfg  = REFMV_RESET;
  logic [2:0]   ref_slot_cfg = REFSLOT_RESET;
  logic         restart_cfg = 1'b1;

  scan_result_t scan_results_due [$];
  plan_row_t    plan [25];

  int           faults = 0;
  int unsigned  cycles = 0;
  logic         quiet_phase = 1'b0;
  int           hold_asks = 0;
  int           hold_served = 0;
  int           hold_left = 0;

  adc_scan_leaky_average_top DUT (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // one step of the scanner: updates the mirror and returns the result
  function automatic void scan_step(input scan_item_t it, output scan_result_t r);
    logic [2:0]  s;
    logic [3:0]  sh;
    logic [24:0] a;
    logic [24:0] v;
    logic [11:0] ref_avg;
    logic [31:0] quot;
    r = '0;
    case (it.cmd)
      CMD_TICK: begin
        if (scan_on) begin
          if (!conv_open) begin
            // a pointer past the last slot falls back to slot 0
            if (slot_ptr >= SLOTS) slot_ptr = '0;
            conv_open = 1'b1;
            r.strobe  = 1'b1;
            r.chan    = slot_ptr;
          end else if (it.done) begin
            s         = slot_ptr;
            conv_open = 1'b0;
            r.chan    = s;
            r.taken   = 1'b1;
            // leaky integrator: add, shift out the average, take it off again
            sh = (shift_cfg > FS_MAX) ? FS_MAX : shift_cfg;
            a  = acc_mirror[s] + it.smp;
            if (a > 25'hFF_FFFF) a = 25'hFF_FFFF;
            v = a >> sh;
            if (v > 25'd4095) v = 25'd4095;
            a = a - v;
            acc_mirror[s] = a[23:0];
            avg_mirror[s] = v[11:0];
            r.avg         = v[11:0];
            if (int'(s) + 1 >= SLOTS) begin
              r.sdone  = 1'b1;
              slot_ptr = '0;
              scan_on  = restart_cfg;
            end else begin
              slot_ptr = s + 3'd1;
            end
          end
        end
      end
      CMD_READ: begin
        r.chan  = it.rslot;
        r.avg   = avg_mirror[it.rslot];
        ref_avg = avg_mirror[ref_slot_cfg];
        // zero reference saturates the quotient
        if (ref_avg == '0) begin
          r.mv = 16'hFFFF;
        end else begin
          quot = r.avg * ref_mv_cfg / ref_avg;
          r.mv = (quot > 32'd65535) ? 16'hFFFF : quot[15:0];
        end
      end
      CMD_START: begin
        slot_ptr  = '0;
        conv_open = 1'b0;
        scan_on   = 1'b1;
      end
      default: begin
        // pause leaves a pending conversion pending
        scan_on = 1'b0;
      end
    endcase
    r.en = scan_on;
  endfunction

  function automatic scan_result_t res(logic st, logic [2:0] ch, logic tk, logic [11:0] av,
                                       logic [15:0] mv, logic sd, logic en);
    res = '{st, ch, tk, av, mv, sd, en};
  endfunction

  function automatic plan_row_t row(cmd_t c, logic d, logic [11:0] smp, logic [2:0] rs,
                                    logic typed, scan_result_t want);
    row = '{'{c, d, smp, rs}, typed, want};
  endfunction

  // one input transfer, with an optional gap before it
  task automatic send_item(input scan_item_t it, input logic typed, input scan_result_t want);
    scan_result_t r;
    if (!quiet_phase && $urandom_range(0, 99) < 24) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    command         <= it.cmd;
    conversion_done <= it.done;
    sample          <= it.smp;
    read_slot       <= it.rslot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    scan_step(it, r);
    scan_results_due.push_back(typed ? want : r);
  endtask

  // stop offering and wait for every awaited result
  task automatic drain();
    in_valid <= 1'b0;
    while (scan_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write; junk in the unused upper data bits must be ignored
  task automatic set_reg(input cfg_reg_t idx, input logic [11:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_FILTER_SHIFT: shift_cfg    = val[3:0];
      REG_REF_MV:       ref_mv_cfg   = val;
      REG_REF_SLOT:     ref_slot_cfg = val[2:0];
      default:          restart_cfg  = val[0];
    endcase
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      faults++;
    end
  endtask

  // result side: check each transfer, then decide the stall for the next edge
  always @(posedge clk) begin
    scan_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (scan_results_due.size() == 0) begin
        $error("result transfer with nothing awaited");
        faults++;
      end else begin
        want = scan_results_due.pop_front();
        check_field("open_strobe", want.strobe, open_strobe);
        check_field("channel_slot", want.chan, channel_slot);
        check_field("sample_taken", want.taken, sample_taken);
        check_field("slot_average", want.avg, slot_average);
        check_field("slot_millivolts", want.mv, slot_millivolts);
        check_field("scan_done", want.sdone, scan_done);
        check_field("scan_enabled", want.en, scan_enabled);
      end
    end
    // long hold-off so the block fills up and stalls its input
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_asks != hold_served) begin
      hold_served++;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet_phase && ($urandom_range(0, 99) < 24);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    scan_item_t  it;
    logic [3:0]  fs;
    logic [11:0] mv;
    logic [2:0]  rs;
    logic        ar;
    int          i;
    int          p;
    int          pick;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table under reset settings: shift 3, 1230 mV, reference slot 2
    plan[0]  = row(CMD_READ,  0, 12'd0,    3'd0, 1, res(0, 0, 0, 12'd0,   16'd65535, 0, 1));
    plan[1]  = row(CMD_READ,  0, 12'd0,    3'd7, 1, res(0, 7, 0, 12'd0,   16'd65535, 0, 1));
    plan[2]  = row(CMD_TICK,  0, 12'd0,    3'd0, 1, res(1, 0, 0, 12'd0,   16'd0, 0, 1));
    // pending but the converter has nothing yet
    plan[3]  = row(CMD_TICK,  0, 12'd4095, 3'd0, 1, res(0, 0, 0, 12'd0,   16'd0, 0, 1));
    plan[4]  = row(CMD_TICK,  1, 12'd4095, 3'd0, 1, res(0, 0, 1, 12'd511, 16'd0, 0, 1));
    plan[5]  = row(CMD_TICK,  1, 12'd0,    3'd5, 1, res(1, 1, 0, 12'd0,   16'd0, 0, 1));
    plan[6]  = row(CMD_TICK,  1, 12'd0,    3'd0, 1, res(0, 1, 1, 12'd0,   16'd0, 0, 1));
    plan[7]  = row(CMD_TICK,  0, 12'd0,    3'd0, 1, res(1, 2, 0, 12'd0,   16'd0, 0, 1));
    // last slot: scan done, auto-restart keeps it enabled
    plan[8]  = row(CMD_TICK,  1, 12'd2048, 3'd0, 1, res(0, 2, 1, 12'd256, 16'd0, 1, 1));
    plan[9]  = row(CMD_READ,  0, 12'd0,    3'd0, 0, '0);
    plan[10] = row(CMD_READ,  0, 12'd0,    3'd2, 0, '0);
    // slot beyond the scan set reads as zero
    plan[11] = row(CMD_READ,  0, 12'd0,    3'd3, 0, '0);
    plan[12] = row(CMD_PAUSE, 1, 12'd4095, 3'd7, 1, res(0, 0, 0, 12'd0,   16'd0, 0, 0));
    // disabled tick does nothing, even with a finished conversion
    plan[13] = row(CMD_TICK,  1, 12'd4095, 3'd0, 1, res(0, 0, 0, 12'd0,   16'd0, 0, 0));
    plan[14] = row(CMD_START, 0, 12'd0,    3'd0, 1, res(0, 0, 0, 12'd0,   16'd0, 0, 1));
    plan[15] = row(CMD_TICK,  0, 12'd0,    3'd0, 0, '0);
    // pause with a conversion pending, then start clears it
    plan[16] = row(CMD_PAUSE, 0, 12'd0,    3'd0, 1, res(0, 0, 0, 12'd0,   16'd0, 0, 0));
    plan[17] = row(CMD_START, 1, 12'd4095, 3'd7, 1, res(0, 0, 0, 12'd0,   16'd0, 0, 1));
    plan[18] = row(CMD_TICK,  1, 12'd100,  3'd0, 0, '0);
    plan[19] = row(CMD_PAUSE, 0, 12'd0,    3'd0, 1, res(0, 0, 0, 12'd0,   16'd0, 0, 0));
    plan[20] = row(CMD_TICK,  1, 12'd100,  3'd0, 0, '0);
    plan[21] = row(CMD_START, 0, 12'd0,    3'd0, 1, res(0, 0, 0, 12'd0,   16'd0, 0, 1));
    plan[22] = row(CMD_TICK,  0, 12'd0,    3'd0, 0, '0);
    plan[23] = row(CMD_TICK,  1, 12'd4095, 3'd0, 0, '0);
    plan[24] = row(CMD_READ,  0, 12'd0,    3'd0, 0, '0);

    foreach (plan[k]) send_item(plan[k].it, plan[k].typed, plan[k].want);
    drain();

    // random phases, each under its own register settings
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin fs = 4'd15; mv = 12'd4095; rs = 3'd0; ar = 1'b0; end
        1: begin fs = 4'd8;  mv = 12'd1;    rs = 3'd1; ar = 1'b0; end
        // shift 0 after shift 8: the first averages saturate
        2: begin fs = 4'd0;  mv = 12'd0;    rs = 3'd7; ar = 1'b1; end
        default: begin
          fs = 4'($urandom_range(0, 15));
          mv = 12'($urandom_range(0, 4095));
          rs = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(3, 7))
                                           : 3'($urandom_range(0, 2));
          ar = 1'($urandom_range(0, 1));
        end
      endcase
      set_reg(REG_FILTER_SHIFT, {8'($urandom), fs});
      set_reg(REG_REF_MV, mv);
      set_reg(REG_REF_SLOT, {9'($urandom), rs});
      set_reg(REG_AUTO_RESTART, {11'($urandom), ar});
      cfg_valid   <= 1'b0;
      quiet_phase <= (p == 4);
      if (p == 1) hold_asks <= hold_asks + 1;

      for (i = 0; i < PHASE_ITEMS; i++) begin
        // mostly ticks, so open and fold pairs walk the scan
        pick = $urandom_range(0, 99);
        it.cmd = (pick < 68) ? CMD_TICK : (pick < 82) ? CMD_READ :
                 (pick < 92) ? CMD_START : CMD_PAUSE;
        it.done = ($urandom_range(0, 99) < 65);
        case ($urandom_range(0, 9))
          0:       it.smp = 12'd0;
          1:       it.smp = 12'hFFF;
          default: it.smp = 12'($urandom_range(0, 4095));
        endcase
        it.rslot = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(3, 7))
                                               : 3'($urandom_range(0, 2));
        send_item(it, 1'b0, '0);
      end
      drain();
    end

    repeat (40) @(posedge clk);
    if (faults == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
